// ===== rtl/core/lrc_pkg.sv =====
// Shared types, constants and the id masking function of the record cache.
package lrc_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int MAX_ID_BYTES    = 32;
    localparam int ID_WORDS        = 4;
    localparam int WORD_W          = 64;
    localparam int ID_BYTES        = ID_WORDS * WORD_W / 8;
    localparam int ID_BITS         = ID_WORDS * WORD_W;
    localparam int FILE_W          = 10;
    localparam int UPD_W           = 32;
    localparam int LEN_W           = 6;
    localparam int HANDLE_W        = 32;
    localparam int CFG_W           = 5;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    localparam logic REG_CACHE_ENTRIES = 1'b0;

    typedef struct packed {
        logic [FILE_W-1:0]  file;
        logic [UPD_W-1:0]   upd;
        logic [LEN_W-1:0]   len;
        logic [ID_BITS-1:0] id;
    } key_t;

    typedef struct packed {
        key_t                key;
        logic [HANDLE_W-1:0] handle;
    } record_t;

    typedef struct packed {
        logic                hit;
        logic [HANDLE_W-1:0] found_handle;
        logic                evicted_valid;
        logic [HANDLE_W-1:0] evicted_handle;
    } result_t;

    // Keeps the first nbytes bytes of the id and zeroes the rest.
    function automatic logic [ID_BITS-1:0] mask_id(input logic [ID_BITS-1:0] id,
                                                   input logic [LEN_W-1:0]   nbytes);
        logic [ID_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < ID_BYTES; b++)
        begin
            if (LEN_W'(b) < nbytes)
            begin
                m[8*b +: 8] = id[8*b +: 8];
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/lru_record_cache.sv =====
// Top level of the recency-ordered record cache with its APB register port.
//
//  Channel   Direction  Handshake                 Payload
//  request   in         req_valid / req_stall     req_type, key fields, data_handle
//  response  out        rsp_valid / rsp_stall     hit, found_handle, evicted_*
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// A lookup scans the n active entries of the entry store, one entry per cycle, and on
// a hit makes a rank pass over the rank store; an insert makes only the rank pass.
// A request that arrives with the cache disabled goes straight to the done state.
// Reset and any write of the size register invalidate every entry at once.
// A finished response waits in the output register while rsp_stall is high, and the
// next request is accepted meanwhile.
module lru_record_cache
    import lrc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  req_type,
    input  logic [FILE_W-1:0]     file_number,
    input  logic [UPD_W-1:0]      update_count,
    input  logic [LEN_W-1:0]      id_length,
    input  logic [WORD_W-1:0]     id_word0,
    input  logic [WORD_W-1:0]     id_word1,
    input  logic [WORD_W-1:0]     id_word2,
    input  logic [WORD_W-1:0]     id_word3,
    input  logic [HANDLE_W-1:0]   data_handle,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic                  hit,
    output logic [HANDLE_W-1:0]   found_handle,
    output logic                  evicted_valid,
    output logic [HANDLE_W-1:0]   evicted_handle
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CFG_W-1:0]  cache_entries_reg, cache_entries_next;
    logic              rsp_valid_reg, rsp_valid_next;
    result_t           rsp_reg;
    logic              cfg_wr;
    logic [LEN_W-1:0]  cmp_len;
    key_t              req_key;
    logic              out_free;
    logic              res_valid;
    result_t           res;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    record_t           ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    record_t           ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CACHE_ENTRIES);
    assign prdata = (paddr[2] == REG_CACHE_ENTRIES)
                    ? APB_DATA_W'(cache_entries_reg) : '0;
    assign cache_entries_next = cfg_wr ? pwdata[CFG_W-1:0] : cache_entries_reg;

    assign cmp_len = (id_length > LEN_W'(MAX_ID_BYTES)) ? LEN_W'(MAX_ID_BYTES) : id_length;
    assign req_key = '{file: file_number, upd: update_count, len: id_length,
                       id: mask_id({id_word3, id_word2, id_word1, id_word0}, cmp_len)};

    assign out_free       = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid_next = res_valid || (rsp_valid_reg && rsp_stall);

    lrc_entry_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lrc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .clear         (cfg_wr),
        .cache_entries (cache_entries_reg),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .req_key       (req_key),
        .req_handle    (data_handle),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_entries_reg <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            cache_entries_reg <= cache_entries_next;
            rsp_valid_reg     <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign hit            = rsp_reg.hit;
    assign found_handle   = rsp_reg.found_handle;
    assign evicted_valid  = rsp_reg.evicted_valid;
    assign evicted_handle = rsp_reg.evicted_handle;

endmodule

// ===== rtl/core/lrc_entry_ram.sv =====
// Entry store of the record cache: one write port and one registered read port.
module lrc_entry_ram
    import lrc_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_ENTRIES,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  record_t           wdata,
    input  logic [ADDR_W-1:0] raddr,
    output record_t           rdata
);

    record_t mem [DEPTH];
    record_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lrc_key_cmp.sv =====
// Key compare unit shared by every step of the lookup scan.
module lrc_key_cmp
    import lrc_pkg::*;
(
    input  logic entry_valid,
    input  key_t entry_key,
    input  key_t req_key,
    output logic match
);

    assign match = entry_valid && (entry_key == req_key);

endmodule

// ===== rtl/core/lrc_ctrl.sv =====
// Request sequencer with recency store, valid bits and scan and rank passes.
module lrc_ctrl
    import lrc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic [CFG_W-1:0]    cache_entries,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                req_type,
    input  key_t                req_key,
    input  logic [HANDLE_W-1:0] req_handle,
    input  logic                out_free,
    output logic                res_valid,
    output result_t             res,
    output logic                ram_we,
    output logic [IDX_W-1:0]    ram_waddr,
    output record_t             ram_wdata,
    output logic [IDX_W-1:0]    ram_raddr,
    input  record_t             ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RANK,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    key_t                 key_reg, key_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     d_idx_reg, d_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_rank_reg, best_rank_next;
    logic [HANDLE_W-1:0]  best_handle_reg, best_handle_next;
    logic                 seen_reg, seen_next;
    logic [IDX_W-1:0]     vic_idx_reg, vic_idx_next;
    logic                 vic_live_reg, vic_live_next;
    logic [HANDLE_W-1:0]  vic_handle_reg, vic_handle_next;
    logic                 evict_reg, evict_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [MAX_ENTRIES-1:0] rank_ok_reg, rank_ok_next;

    logic [IDX_W-1:0]     rank_mem [MAX_ENTRIES];
    logic [IDX_W-1:0]     rank_rd_reg;
    logic                 rank_we;
    logic [IDX_W-1:0]     rank_wdata;
    logic [IDX_W-1:0]     rank_cur;
    logic [IDX_W-1:0]     raddr;
    logic [CNT_W-1:0]     n_act;
    logic                 key_match;

    assign n_act = (9'(cache_entries) > 9'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(cache_entries);
    assign raddr     = (cnt_reg < n_reg) ? cnt_reg[IDX_W-1:0] : '0;
    assign rank_cur  = rank_ok_reg[d_idx_reg] ? rank_rd_reg : d_idx_reg;
    assign ram_raddr = raddr;
    assign ram_waddr = vic_idx_reg;
    assign ram_wdata = '{key: key_reg, handle: handle_reg};
    assign req_stall = (state_reg != ST_IDLE);

    lrc_key_cmp u_cmp (
        .entry_valid (valid_reg[d_idx_reg]),
        .entry_key   (ram_rdata.key),
        .req_key     (key_reg),
        .match       (key_match)
    );

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        handle_next      = handle_reg;
        n_next           = n_reg;
        cnt_next         = cnt_reg;
        d_idx_next       = d_idx_reg;
        found_next       = found_reg;
        best_rank_next   = best_rank_reg;
        best_handle_next = best_handle_reg;
        seen_next        = seen_reg;
        vic_idx_next     = vic_idx_reg;
        vic_live_next    = vic_live_reg;
        vic_handle_next  = vic_handle_reg;
        evict_next       = evict_reg;
        valid_next       = valid_reg;
        rank_ok_next     = rank_ok_reg;
        rank_we          = 1'b0;
        rank_wdata       = '0;
        ram_we           = 1'b0;
        res_valid        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req_type;
                    key_next    = req_key;
                    handle_next = req_handle;
                    n_next      = n_act;
                    cnt_next    = '0;
                    found_next  = 1'b0;
                    seen_next   = 1'b0;
                    evict_next  = 1'b0;
                    if (n_act == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (req_type == REQ_LOOKUP)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        best_rank_next = IDX_W'(n_act - 1'b1);
                        state_next     = ST_RANK;
                    end
                end
            end
            ST_SCAN:
            begin
                cnt_next   = CNT_W'(cnt_reg + 1'b1);
                d_idx_next = raddr;
                if ((cnt_reg != '0) && key_match && (!found_reg || (rank_cur < best_rank_reg)))
                begin
                    found_next       = 1'b1;
                    best_rank_next   = rank_cur;
                    best_handle_next = ram_rdata.handle;
                end
                if (cnt_reg == n_reg)
                begin
                    cnt_next   = '0;
                    state_next = found_next ? ST_RANK : ST_DONE;
                end
            end
            ST_RANK:
            begin
                cnt_next   = CNT_W'(cnt_reg + 1'b1);
                d_idx_next = raddr;
                if (cnt_reg != '0)
                begin
                    rank_we = 1'b1;
                    if (rank_cur == best_rank_reg)
                    begin
                        rank_wdata      = '0;
                        seen_next       = 1'b1;
                        vic_idx_next    = d_idx_reg;
                        vic_live_next   = valid_reg[d_idx_reg];
                        vic_handle_next = ram_rdata.handle;
                    end
                    else if (rank_cur < best_rank_reg)
                    begin
                        rank_wdata = IDX_W'(rank_cur + 1'b1);
                    end
                    else
                    begin
                        rank_wdata = rank_cur;
                    end
                    rank_ok_next[d_idx_reg] = 1'b1;
                end
                if (cnt_reg == n_reg)
                begin
                    cnt_next   = '0;
                    state_next = (op_reg == REQ_INSERT) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                ram_we                  = 1'b1;
                valid_next[vic_idx_reg] = 1'b1;
                evict_next              = vic_live_reg && (vic_handle_reg != '0);
                state_next              = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (clear)
        begin
            valid_next   = '0;
            rank_ok_next = '0;
        end
    end

    always_comb
    begin
        res.hit            = (op_reg == REQ_LOOKUP) && found_reg;
        res.found_handle   = res.hit ? best_handle_reg : '0;
        res.evicted_valid  = (op_reg == REQ_INSERT) && evict_reg;
        res.evicted_handle = res.evicted_valid ? vic_handle_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            rank_ok_reg <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            found_reg   <= 1'b0;
            seen_reg    <= 1'b0;
            evict_reg   <= 1'b0;
            op_reg      <= REQ_LOOKUP;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rank_ok_reg <= rank_ok_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            found_reg   <= found_next;
            seen_reg    <= seen_next;
            evict_reg   <= evict_next;
            op_reg      <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        handle_reg      <= handle_next;
        d_idx_reg       <= d_idx_next;
        best_rank_reg   <= best_rank_next;
        best_handle_reg <= best_handle_next;
        vic_idx_reg     <= vic_idx_next;
        vic_live_reg    <= vic_live_next;
        vic_handle_reg  <= vic_handle_next;
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[d_idx_reg] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[raddr];
    end

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (valid_reg == '0) && (rank_ok_reg == '0))
        else $error("entries survived a size register write");

    a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) <= int'(n_act))
        else $error("more valid entries than the cache size allows");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK) && (cnt_reg == n_reg) |->
            (seen_reg || (rank_cur == best_rank_reg)))
        else $error("rank pass found no entry holding the target rank");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        rank_we |-> (CNT_W'(rank_wdata) < n_reg))
        else $error("rank written outside the active range");

    a_disabled_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && req_valid && (n_act == '0) |=> (state_reg == ST_DONE))
        else $error("request with the cache disabled did not finish at once");

endmodule

// ===== bench/tb_lru_record_cache.sv =====
// Self-checking testbench for the recency-ordered record cache.
`timescale 1ns / 100ps

module tb_lru_record_cache;
    import lrc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_COUNT = 9;
    localparam logic [APB_ADDR_W-1:0] CACHE_ENTRIES_ADDR = APB_ADDR_W'(4 * REG_CACHE_ENTRIES);

    localparam bit CHECK_TYPED = 1'b1;
    localparam bit CHECK_MODEL = 1'b0;
    localparam bit RESIZE = 1'b1;
    localparam bit KEEP = 1'b0;

    localparam logic [ID_BITS-1:0] ID_ONES = {ID_BITS{1'b1}};
    localparam logic [ID_BITS-1:0] ID_PATTERN = {4{64'h0123_4567_89ab_cdef}};
    localparam logic [ID_BITS-1:0] ID_SHORT_A = {{27{8'h5a}}, 40'hc3_a5_0f_f0_99};
    localparam logic [ID_BITS-1:0] ID_SHORT_B = {{27{8'ha5}}, 40'hc3_a5_0f_f0_99};
    localparam logic [ID_BITS-1:0] ID_SHORT_C = {{27{8'h5a}}, 40'h3c_a5_0f_f0_99};

    localparam result_t NO_RESULT = '0;
    localparam result_t EVICT_11 = '{hit: 1'b0, found_handle: '0,
                                     evicted_valid: 1'b1, evicted_handle: 32'h11};

    typedef struct packed {
        logic                kind;
        logic [FILE_W-1:0]   file;
        logic [UPD_W-1:0]    upd;
        logic [LEN_W-1:0]    len;
        logic [ID_BITS-1:0]  id;
        logic [HANDLE_W-1:0] handle;
    } cache_req_t;

    typedef struct {
        bit               resize;
        logic [CFG_W-1:0] size;
        cache_req_t       rq;
        bit               typed;
        result_t          want;
    } stim_row_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    logic                  req_type = REQ_LOOKUP;
    logic [FILE_W-1:0]     file_number = '0;
    logic [UPD_W-1:0]      update_count = '0;
    logic [LEN_W-1:0]      id_length = '0;
    logic [WORD_W-1:0]     id_word0 = '0;
    logic [WORD_W-1:0]     id_word1 = '0;
    logic [WORD_W-1:0]     id_word2 = '0;
    logic [WORD_W-1:0]     id_word3 = '0;
    logic [HANDLE_W-1:0]   data_handle = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    logic                  hit;
    logic [HANDLE_W-1:0]   found_handle;
    logic                  evicted_valid;
    logic [HANDLE_W-1:0]   evicted_handle;

    // Shadow copy of the cache contents and recency order.
    logic [CFG_W-1:0]    size_setting;
    bit                  slot_used [DEF_MAX_ENTRIES];
    logic [FILE_W-1:0]   slot_file [DEF_MAX_ENTRIES];
    logic [UPD_W-1:0]    slot_upd [DEF_MAX_ENTRIES];
    logic [LEN_W-1:0]    slot_len [DEF_MAX_ENTRIES];
    logic [ID_BITS-1:0]  slot_id [DEF_MAX_ENTRIES];
    logic [HANDLE_W-1:0] slot_handle [DEF_MAX_ENTRIES];
    int                  slot_rank [DEF_MAX_ENTRIES];

    result_t     pending_responses [$];
    cache_req_t  recent_keys [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          run_left = 0;
    bit          run_level = 1'b0;

    lru_record_cache dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** lru_record_cache: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
            default:
            begin
                if (run_left == 0)
                begin
                    run_level = !run_level;
                    run_left = $urandom_range(1, 20);
                end
                else
                begin
                    run_left--;
                end
                rsp_stall <= run_level;
            end
        endcase
    end

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        if (mismatch_count < 50)
        begin
            $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (pending_responses.size() == 0)
            begin
                report("response with no request outstanding", '0, '0);
            end
            else
            begin
                want = pending_responses.pop_front();
                if (hit !== want.hit)
                    report("hit", want.hit, hit);
                if (found_handle !== want.found_handle)
                    report("found_handle", want.found_handle, found_handle);
                if (evicted_valid !== want.evicted_valid)
                    report("evicted_valid", want.evicted_valid, evicted_valid);
                if (evicted_handle !== want.evicted_handle)
                    report("evicted_handle", want.evicted_handle, evicted_handle);
            end
        end
    end

    function automatic logic [ID_BITS-1:0] id_keep_mask(input logic [LEN_W-1:0] len);
        int nbytes;
        nbytes = (len > MAX_ID_BYTES) ? MAX_ID_BYTES : int'(len);
        if (nbytes == 0)
            return '0;
        return ID_ONES >> (ID_BITS - 8 * nbytes);
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < DEF_MAX_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_rank[i] = i;
        end
    endfunction

    function automatic void promote(input int e, input int n);
        int r;
        r = slot_rank[e];
        for (int i = 0; i < n; i++)
        begin
            if (slot_rank[i] < r)
                slot_rank[i]++;
        end
        slot_rank[e] = 0;
    endfunction

    function automatic result_t predict_cache_response(input cache_req_t r);
        result_t            res;
        int                 n;
        int                 best;
        int                 best_rank;
        int                 victim;
        logic [ID_BITS-1:0] id;
        bit                 match;
        res = '0;
        n = (size_setting > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(size_setting);
        id = r.id & id_keep_mask(r.len);
        if (n == 0)
            return res;
        if (r.kind == REQ_LOOKUP)
        begin
            best = -1;
            best_rank = 0;
            for (int i = 0; i < n; i++)
            begin
                match = slot_used[i] && slot_file[i] == r.file && slot_upd[i] == r.upd
                        && slot_len[i] == r.len && slot_id[i] == id;
                if (match && (best < 0 || slot_rank[i] < best_rank))
                begin
                    best = i;
                    best_rank = slot_rank[i];
                end
            end
            if (best >= 0)
            begin
                res.hit = 1'b1;
                res.found_handle = slot_handle[best];
                promote(best, n);
            end
        end
        else
        begin
            victim = 0;
            for (int i = 0; i < n; i++)
            begin
                if (slot_rank[i] == n - 1)
                    victim = i;
            end
            if (slot_used[victim] && slot_handle[victim] != 0)
            begin
                res.evicted_valid = 1'b1;
                res.evicted_handle = slot_handle[victim];
            end
            slot_used[victim] = 1'b1;
            slot_file[victim] = r.file;
            slot_upd[victim] = r.upd;
            slot_len[victim] = r.len;
            slot_id[victim] = id;
            slot_handle[victim] = r.handle;
            promote(victim, n);
        end
        return res;
    endfunction

    function automatic logic [ID_BITS-1:0] random_id();
        logic [ID_BITS-1:0] id;
        for (int w = 0; w < ID_BITS / 32; w++)
            id[32*w +: 32] = $urandom;
        return id;
    endfunction

    function automatic cache_req_t fresh_key();
        cache_req_t k;
        int         pick;
        k.kind = REQ_LOOKUP;
        k.file = ($urandom_range(0, 3) == 0) ? FILE_W'($urandom_range(0, 3))
                                               : FILE_W'($urandom_range(0, 1023));
        k.upd = ($urandom_range(0, 4) == 0) ? UPD_W'($urandom_range(0, 2)) : UPD_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 7)
            k.len = LEN_W'($urandom_range(0, 32));
        else if (pick < 8)
            k.len = LEN_W'(MAX_ID_BYTES);
        else
            k.len = LEN_W'($urandom_range(33, 63));
        k.id = random_id();
        k.handle = '0;
        return k;
    endfunction

    // Mostly inserts of new keys and lookups of keys recently inserted, with near misses
    // and stray keys mixed in.
    function automatic cache_req_t next_random_request();
        cache_req_t         r;
        cache_req_t         k;
        logic [ID_BITS-1:0] keep;
        int                 pick;
        int                 cap;
        int                 b;
        pick = $urandom_range(0, 99);
        k = (recent_keys.size() != 0) ? recent_keys[$urandom_range(0, recent_keys.size() - 1)]
                                      : fresh_key();
        if (pick < 12)
        begin
            r = k;
        end
        else if (pick < 40 || pick >= 95)
        begin
            r = fresh_key();
        end
        else
        begin
            r = k;
            keep = id_keep_mask(r.len);
            r.id = (r.id & keep) | (random_id() & ~keep);
            if (pick >= 80)
            begin
                case ($urandom_range(0, 3))
                    0: r.file[$urandom_range(0, FILE_W - 1)] ^= 1'b1;
                    1: r.upd[$urandom_range(0, UPD_W - 1)] ^= 1'b1;
                    2: r.len[$urandom_range(0, LEN_W - 1)] ^= 1'b1;
                    default:
                    begin
                        b = $urandom_range(0, ID_BYTES - 1);
                        r.id[8*b +: 8] ^= 8'($urandom_range(1, 255));
                    end
                endcase
            end
        end
        r.kind = (pick < 40 || pick >= 97) ? REQ_INSERT : REQ_LOOKUP;
        case ($urandom_range(0, 19))
            0, 1, 2: r.handle = '0;
            3:       r.handle = '1;
            default: r.handle = $urandom;
        endcase
        if (r.kind == REQ_INSERT)
        begin
            cap = ((size_setting > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(size_setting)) + 3;
            recent_keys.push_back(r);
            while (recent_keys.size() > cap)
                void'(recent_keys.pop_front());
        end
        return r;
    endfunction

    task automatic send_request(input cache_req_t r, input bit typed, input result_t want);
        result_t predicted;
        req_valid <= 1'b1;
        req_type <= r.kind;
        file_number <= r.file;
        update_count <= r.upd;
        id_length <= r.len;
        id_word0 <= r.id[0*WORD_W +: WORD_W];
        id_word1 <= r.id[1*WORD_W +: WORD_W];
        id_word2 <= r.id[2*WORD_W +: WORD_W];
        id_word3 <= r.id[3*WORD_W +: WORD_W];
        data_handle <= r.handle;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = predict_cache_response(r);
        pending_responses.push_back(typed ? want : predicted);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_responses();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    task automatic set_cache_entries(input logic [CFG_W-1:0] n);
        wait_for_responses();
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CACHE_ENTRIES_ADDR;
        pwdata <= APB_DATA_W'(n);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        size_setting = n;
        clear_slots();
        recent_keys.delete();
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== APB_DATA_W'(n))
            report("cache_entries readback", n, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input bit resize, input logic [CFG_W-1:0] size, input logic kind,
                           input logic [FILE_W-1:0] file, input logic [UPD_W-1:0] upd,
                           input logic [LEN_W-1:0] len, input logic [ID_BITS-1:0] id,
                           input logic [HANDLE_W-1:0] handle, input bit typed,
                           input result_t want);
        stim_row_t row;
        row.resize = resize;
        row.size = size;
        row.rq = '{kind: kind, file: file, upd: upd, len: len, id: id, handle: handle};
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        logic [CFG_W-1:0] sz;
        int               count;
        int               pause_at;
        size_setting = '0;
        clear_slots();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The cache is disabled after reset.
        add_row(KEEP, 0, REQ_LOOKUP, 10'h3ff, 32'hffff_ffff, 6'd63, ID_ONES, 32'hffff_ffff,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'h3ff, 32'hffff_ffff, 6'd63, ID_ONES, 32'hffff_ffff,
                CHECK_TYPED, NO_RESULT);
        // A single entry: a zero-length id ignores the id bytes, and a second insert evicts.
        add_row(RESIZE, 1, REQ_INSERT, 10'd0, 32'd0, 6'd0, '0, 32'h11, CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd0, 32'd0, 6'd0, ID_ONES, 32'd0, CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'h3ff, 32'hffff_ffff, 6'd32, ID_ONES, 32'h22,
                CHECK_TYPED, EVICT_11);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd0, 32'd0, 6'd0, '0, 32'd0, CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'h3ff, 32'hffff_ffff, 6'd32, ID_ONES, 32'd0,
                CHECK_MODEL, NO_RESULT);
        // Two entries: null handles are found but never reported as evicted.
        add_row(RESIZE, 2, REQ_INSERT, 10'd5, 32'd100, 6'd8, ID_PATTERN, 32'd0,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd6, 32'd200, 6'd16, ID_PATTERN, 32'hffff_ffff,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd5, 32'd100, 6'd8, ID_PATTERN, 32'd0,
                CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd7, 32'd300, 6'd24, ID_PATTERN, 32'd5,
                CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd8, 32'd400, 6'd1, ID_PATTERN, 32'd6,
                CHECK_MODEL, NO_RESULT);
        // Full size: long ids, partial ids and duplicate keys.
        add_row(RESIZE, 16, REQ_INSERT, 10'd200, 32'h1234_5678, 6'd63, ID_PATTERN, 32'h100,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd200, 32'h1234_5678, 6'd63, ID_PATTERN, 32'd0,
                CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd200, 32'h1234_5678, 6'd32, ID_PATTERN, 32'd0,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd201, 32'd1, 6'd5, ID_SHORT_A, 32'h200,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd201, 32'd1, 6'd5, ID_SHORT_B, 32'd0,
                CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd201, 32'd1, 6'd5, ID_SHORT_C, 32'd0,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'd7,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'd9,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'd0,
                CHECK_MODEL, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd301, 32'd7, 6'd12, ID_PATTERN, 32'd0,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd300, 32'd6, 6'd12, ID_PATTERN, 32'd0,
                CHECK_TYPED, NO_RESULT);
        // An oversized setting saturates, and the write itself empties the cache.
        add_row(RESIZE, 31, REQ_LOOKUP, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'd0,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_INSERT, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'hffff_ffff,
                CHECK_TYPED, NO_RESULT);
        add_row(KEEP, 0, REQ_LOOKUP, 10'd300, 32'd7, 6'd12, ID_PATTERN, 32'd0,
                CHECK_MODEL, NO_RESULT);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].resize)
                set_cache_entries(directed_rows[i].size);
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
            pace_sender();
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: sz = 5'd1;
                1: sz = 5'd16;
                2: sz = 5'd31;
                3: sz = 5'd0;
                4: sz = 5'd3;
                5: sz = 5'd17;
                6: sz = 5'd2;
                7: sz = 5'd8;
                default: sz = CFG_W'($urandom_range(0, 31));
            endcase
            set_cache_entries(sz);
            count = (sz == 0) ? 40 : 165;
            pause_at = $urandom_range(10, count - 10);
            for (int k = 0; k < count; k++)
            begin
                if (k == pause_at)
                    wait_for_responses();
                send_request(next_random_request(), CHECK_MODEL, NO_RESULT);
                pace_sender();
            end
        end

        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** lru_record_cache: PASSED **");
        else
            $display("** lru_record_cache: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lrc_pkg.sv
rtl/core/lrc_entry_ram.sv
rtl/core/lrc_key_cmp.sv
rtl/core/lrc_ctrl.sv
rtl/core/lru_record_cache.sv
bench/tb_lru_record_cache.sv
